/* hw/rtl/scl_pkg.sv */
// ----------------------------------------------------------------------------
// scl_pkg
// Shared constants, types and the command text table for the serial command
// line recognizer.
// ----------------------------------------------------------------------------
package scl_pkg;

   // line store geometry
   localparam int LINE_CAPACITY = 64;
   localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int COUNT_W       = $clog2(STORE_DEPTH + 1);

   // byte codes
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_UA = 8'h41;
   localparam logic [7:0] CHAR_UZ = 8'h5A;

   // response kinds
   localparam logic [2:0] KIND_OVERFLOW = 3'd0;
   localparam logic [2:0] KIND_VERSION  = 3'd1;
   localparam logic [2:0] KIND_HELP     = 3'd2;
   localparam logic [2:0] KIND_HELP_TM  = 3'd3;
   localparam logic [2:0] KIND_TM_ON    = 3'd4;
   localparam logic [2:0] KIND_TM_OFF   = 3'd5;
   localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

   // command table, lower case, right-justified in 16 characters
   localparam int NUM_CMDS = 5;
   localparam int CMD_MAX  = 16;
   localparam logic [CMD_MAX*8-1:0] CMD_TEXT [NUM_CMDS] = '{
      "getversion", "help", "help testmode", "testmode on", "testmode off"
   };
   localparam int CMD_LEN [NUM_CMDS] = '{10, 4, 13, 11, 12};

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic               start;    // load length checks, arm all flags
      logic               cmp_vld;  // store read data is valid this cycle
      logic [COUNT_W-1:0] cmp_idx;  // character position of that data
   } scl_cmp_ctl_type;

   // fold upper-case ASCII letters to lower case
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UA && c <= CHAR_UZ) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   // character at a given position of a command, zero beyond its end
   function automatic logic [7:0] cmd_char(input int cmd, input logic [COUNT_W-1:0] pos);
      logic [7:0] r;
      logic [6:0] sh;
      r  = 8'h00;
      sh = '0;
      if (int'(pos) < CMD_LEN[cmd]) begin
         sh = 7'(CMD_LEN[cmd] - 1 - int'(pos));
         r  = CMD_TEXT[cmd][sh*8 +: 8];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/scl_line_store.sv */
// ----------------------------------------------------------------------------
// scl_line_store
// Line character memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module scl_line_store (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [scl_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic                      rd_en,
   input  logic [scl_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [scl_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/scl_matcher.sv */
// ----------------------------------------------------------------------------
// scl_matcher
// Shared compare unit: checks one stored character per cycle against the
// same position of every command and keeps one running match flag each.
// ----------------------------------------------------------------------------
module scl_matcher (
   input  logic                        clock,
   input  scl_pkg::scl_cmp_ctl_type    ctl,
   input  logic [scl_pkg::COUNT_W-1:0] line_count,
   input  logic [7:0]                  rd_data,
   output logic [scl_pkg::NUM_CMDS-1:0] match
);

   logic [scl_pkg::NUM_CMDS-1:0] match_ff;
   logic [scl_pkg::NUM_CMDS-1:0] match_in;
   logic [7:0]                   folded;

   assign folded = scl_pkg::fold_case(rd_data);

   // length check on start, then one character per compare cycle
   always_comb begin
      match_in = match_ff;
      for (int c = 0; c < scl_pkg::NUM_CMDS; c++) begin
         if (ctl.start) begin
            match_in[c] = (line_count == scl_pkg::COUNT_W'(scl_pkg::CMD_LEN[c]));
         end else if (ctl.cmp_vld) begin
            match_in[c] = match_ff[c] && (folded == scl_pkg::cmd_char(c, ctl.cmp_idx));
         end
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

   assign match = match_ff;

endmodule

/* hw/rtl/serial_command_line_recognizer.sv */
// ----------------------------------------------------------------------------
// serial_command_line_recognizer
// Collects bytes into a line, matches a finished line against five commands
// and returns a response kind, or echoes an unknown line byte by byte.
// ----------------------------------------------------------------------------
// Ordinary bytes: one per cycle while idle, no result.
// Terminator on a stored line: the compare unit scans each character, then
//   the result is registered from ST_OUT, or the echo begins.
// Overflowed line: result registered from ST_OUT after its terminator.
// Echo runs byte by byte (store read, then output in ST_ECHO_WR); input is
//   held off from the terminator until the last result is registered.
// Reset (synchronous, active high) empties the line and clears the flags.
module serial_command_line_recognizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] echo_byte, [8] mode flag now, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] response_kind
   output logic        rsp_tlast    // last
);

   localparam int CW = scl_pkg::COUNT_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_OUT     = 3'd2;
   localparam logic [2:0] ST_ECHO_RD = 3'd3;
   localparam logic [2:0] ST_ECHO_WR = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          tm_ff, tm_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [CW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [2:0]    kind_ff, kind_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_echo_ff, rsp_echo_in;
   logic          rsp_tm_ff, rsp_tm_in;
   logic          rsp_last_ff, rsp_last_in;

   logic                         wr_en, rd_en, start, out_free, accept, is_term;
   logic [7:0]                   rd_data;
   logic [scl_pkg::NUM_CMDS-1:0] match;
   logic [2:0]                   found_kind;
   scl_pkg::scl_cmp_ctl_type     cmp_ctl;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_term    = (req_tdata == scl_pkg::CHAR_CR) || (req_tdata == scl_pkg::CHAR_LF);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wr_en      = accept && !is_term && !ovf_ff &&
                       (count_ff < CW'(scl_pkg::STORE_DEPTH));

   // line store and compare unit
   scl_line_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[scl_pkg::ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[scl_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign cmp_ctl.start   = start;
   assign cmp_ctl.cmp_vld = cmp_vld_ff;
   assign cmp_ctl.cmp_idx = cmp_idx_ff;

   scl_matcher u_match (
      .clock      (clock),
      .ctl        (cmp_ctl),
      .line_count (count_ff),
      .rd_data    (rd_data),
      .match      (match)
   );

   // first matching command in table order
   always_comb begin
      found_kind = scl_pkg::KIND_UNKNOWN;
      if (match[0]) begin
         found_kind = scl_pkg::KIND_VERSION;
      end else if (match[1]) begin
         found_kind = scl_pkg::KIND_HELP;
      end else if (match[2]) begin
         found_kind = scl_pkg::KIND_HELP_TM;
      end else if (match[3]) begin
         found_kind = scl_pkg::KIND_TM_ON;
      end else if (match[4]) begin
         found_kind = scl_pkg::KIND_TM_OFF;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      tm_in        = tm_ff;
      idx_in       = idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = idx_ff;
      kind_in      = kind_ff;
      start        = 1'b0;
      rd_en        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_tm_in    = rsp_tm_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!is_term) begin
                  if (wr_en) begin
                     count_in = count_ff + CW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (ovf_ff) begin
                  kind_in  = scl_pkg::KIND_OVERFLOW;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_OUT;
               end else if (count_ff != '0) begin
                  start    = 1'b1;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               idx_in     = idx_ff + CW'(1);
            end else if (!cmp_vld_ff) begin
               idx_in = '0;
               if (found_kind == scl_pkg::KIND_UNKNOWN) begin
                  state_in = ST_ECHO_RD;
               end else begin
                  kind_in  = found_kind;
                  count_in = '0;
                  state_in = ST_OUT;
                  if (found_kind == scl_pkg::KIND_TM_ON) begin
                     tm_in = 1'b1;
                  end else if (found_kind == scl_pkg::KIND_TM_OFF) begin
                     tm_in = 1'b0;
                  end
               end
            end
         end

         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_echo_in  = 8'h00;
               rsp_tm_in    = tm_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_ECHO_RD: begin
            rd_en    = 1'b1;
            state_in = ST_ECHO_WR;
         end

         ST_ECHO_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = scl_pkg::KIND_UNKNOWN;
               rsp_echo_in  = rd_data;
               rsp_tm_in    = tm_ff;
               rsp_last_in  = (idx_ff + CW'(1) == count_ff);
               idx_in       = idx_ff + CW'(1);
               if (idx_ff + CW'(1) == count_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ECHO_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         tm_ff        <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         tm_ff        <= tm_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      kind_ff     <= kind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_echo_ff <= rsp_echo_in;
      rsp_tm_ff   <= rsp_tm_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_tm_ff, rsp_echo_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // line count never passes the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(scl_pkg::STORE_DEPTH))
      else $error("line count beyond store depth");

   // overflow is only raised on a full store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CW'(scl_pkg::STORE_DEPTH)))
      else $error("overflow flag set with store not full");

   // echo index stays inside the stored line
   a_echo_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ECHO_RD || state_ff == ST_ECHO_WR) |-> (idx_ff < count_ff))
      else $error("echo index past line end");

   // only echo results carry a byte
   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != scl_pkg::KIND_UNKNOWN) |-> (rsp_echo_ff == 8'h00))
      else $error("nonzero echo byte on a command result");
`endif

endmodule
